/* rtl/atm_pkg.sv */
// ----------------------------------------------------------------------------
// atm_pkg: shared types and constants of the alarm table matcher
// Slot count, repeat codes, stream payload layouts and the control interface
// between the scan controller and the datapath.
// ----------------------------------------------------------------------------
package atm_pkg;

  localparam int ALARM_SLOTS = 8;
  localparam int MAX_FIRINGS = 8;

  localparam int SLOT_IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int IDX_EXT_W  = (SLOT_IDX_W > 3) ? SLOT_IDX_W : 3;
  localparam int FIRE_CNT_W = (MAX_FIRINGS > 1) ? $clog2(MAX_FIRINGS) : 1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [3:0] WDAY_NONE     = 4'd0;
  localparam logic [3:0] WDAY_EVERY    = 4'd1;
  localparam logic [3:0] WDAY_WORKDAYS = 4'd8;
  localparam logic [3:0] WDAY_WEEKEND  = 4'd9;
  localparam logic [5:0] MDAY_NONE     = 6'd0;

  localparam logic [2:0] SUNDAY   = 3'd0;
  localparam logic [2:0] SATURDAY = 3'd6;

  localparam logic [6:0] NO_MINUTE = 7'd127;

  typedef struct packed {
    logic [3:0] pad;
    logic [4:0] now_monthday;
    logic [2:0] now_weekday;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [5:0] repeat_monthday;
    logic [3:0] repeat_weekday;
    logic [5:0] alarm_minute;
    logic [4:0] alarm_hour;
    logic       entry_valid;
    logic [2:0] slot;
  } atm_in_t;

  typedef struct packed {
    logic [3:0] pad;
    logic       was_one_shot;
    logic [2:0] fired_slot;
  } atm_out_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [3:0] wday_code;
    logic [5:0] mday_code;
  } atm_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } atm_state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic flush;
  } atm_cmd_t;

  typedef struct packed {
    logic tick_scan;
    logic fire;
    logic scan_end;
    logic pend_valid;
    logic out_free;
  } atm_status_t;

endpackage

/* rtl/atm_ctrl.sv */
// ----------------------------------------------------------------------------
// atm_ctrl: scan controller of the alarm table matcher
// Accepts one item at a time, walks the table during a scan and flushes the
// final firing with its last flag.
// ----------------------------------------------------------------------------
module atm_ctrl import atm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  atm_status_t status,
  output atm_cmd_t    cmd
);

  atm_state_t state;
  atm_state_t state_next;
  logic       stall;

  assign stall = status.fire && status.pend_valid && !status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && status.tick_scan) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall && status.scan_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    cmd.flush  = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_SCAN: begin
        cmd.step = !stall;
      end
      ST_FLUSH: begin
        cmd.flush = status.pend_valid && status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/atm_datapath.sv */
// ----------------------------------------------------------------------------
// atm_datapath: alarm table, scan pointer and result registers
// Holds the slot table with its valid bits, matches one slot per cycle unless stalled and
// keeps one pending firing ahead of the output register.
// ----------------------------------------------------------------------------
module atm_datapath import atm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic [47:0] s_tdata,
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  input  atm_cmd_t    cmd,
  output atm_status_t status
);

  atm_in_t                 in_item;
  atm_entry_t              table_data [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0]  table_valid;
  logic                    once_per_minute;
  logic [6:0]              last_minute;
  logic [4:0]              now_hour;
  logic [5:0]              now_minute;
  logic [2:0]              now_weekday;
  logic [4:0]              now_monthday;
  logic [SLOT_IDX_W-1:0]   idx;
  logic [FIRE_CNT_W-1:0]   fire_cnt;
  logic                    pend_valid;
  logic [2:0]              pend_slot;
  logic                    pend_one_shot;
  atm_out_t                out_data;
  logic                    out_last;
  logic [IDX_EXT_W-1:0]    wr_ext;
  logic [IDX_EXT_W-1:0]    idx_ext;
  logic                    wr_in_range;
  logic                    tick_skip;
  atm_entry_t              cur;
  logic                    cur_one_shot;
  logic                    rule_ok;
  logic                    wday_ok;
  logic [3:0]              wday_less;
  logic [5:0]              mday_less;
  logic                    out_load;

  assign in_item     = atm_in_t'(s_tdata);
  assign wr_ext      = IDX_EXT_W'(in_item.slot);
  assign idx_ext     = IDX_EXT_W'(idx);
  assign wr_in_range = int'(in_item.slot) < ALARM_SLOTS;
  assign tick_skip   = once_per_minute && ({1'b0, in_item.now_minute} == last_minute);

  assign cur          = table_data[idx];
  assign wday_less    = cur.wday_code - 4'd1;
  assign mday_less    = cur.mday_code - 6'd1;
  assign cur_one_shot = (cur.wday_code == WDAY_NONE) && (cur.mday_code == MDAY_NONE);

  always_comb begin
    if (cur.wday_code == WDAY_EVERY || wday_less == {1'b0, now_weekday}) begin
      wday_ok = 1'b1;
    end else if (now_weekday inside {SUNDAY, SATURDAY}) begin
      wday_ok = cur.wday_code == WDAY_WEEKEND;
    end else begin
      wday_ok = cur.wday_code == WDAY_WORKDAYS;
    end
    if (cur.wday_code != WDAY_NONE) begin
      rule_ok = wday_ok;
    end else if (cur.mday_code != MDAY_NONE) begin
      rule_ok = mday_less == {1'b0, now_monthday};
    end else begin
      rule_ok = 1'b1;
    end
  end

  assign status.tick_scan  = (s_tuser == CMD_TICK) && !tick_skip;
  assign status.fire       = table_valid[idx] && (cur.hour == now_hour) &&
                             (cur.minute == now_minute) && rule_ok;
  assign status.scan_end   = (idx == SLOT_IDX_W'(ALARM_SLOTS - 1)) ||
                             (status.fire && fire_cnt == FIRE_CNT_W'(MAX_FIRINGS - 1));
  assign status.pend_valid = pend_valid;
  assign status.out_free   = !m_tvalid || m_tready;

  assign out_load = (cmd.step && status.fire && pend_valid) || cmd.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      once_per_minute <= 1'b0;
    end else if (cfg_we) begin
      once_per_minute <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && s_tuser == CMD_WRITE && wr_in_range) begin
      table_data[wr_ext[SLOT_IDX_W-1:0]] <= '{
        hour:      in_item.alarm_hour,
        minute:    in_item.alarm_minute,
        wday_code: in_item.repeat_weekday,
        mday_code: in_item.repeat_monthday
      };
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_valid <= '0;
    end else if (cmd.accept && s_tuser == CMD_WRITE && wr_in_range) begin
      table_valid[wr_ext[SLOT_IDX_W-1:0]] <= in_item.entry_valid;
    end else if (cmd.step && status.fire && cur_one_shot) begin
      table_valid[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_minute <= NO_MINUTE;
      idx         <= '0;
      fire_cnt    <= '0;
      pend_valid  <= 1'b0;
    end else if (cmd.accept) begin
      if (status.tick_scan) begin
        last_minute <= {1'b0, in_item.now_minute};
        idx         <= '0;
        fire_cnt    <= '0;
        pend_valid  <= 1'b0;
      end
    end else if (cmd.step) begin
      idx <= idx + 1'b1;
      if (status.fire) begin
        fire_cnt   <= fire_cnt + 1'b1;
        pend_valid <= 1'b1;
      end
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && status.tick_scan) begin
      now_hour     <= in_item.now_hour;
      now_minute   <= in_item.now_minute;
      now_weekday  <= in_item.now_weekday;
      now_monthday <= in_item.now_monthday;
    end
    if (cmd.step && status.fire) begin
      pend_slot     <= idx_ext[2:0];
      pend_one_shot <= cur_one_shot;
    end
    if (out_load) begin
      out_data.pad          <= '0;
      out_data.fired_slot   <= pend_slot;
      out_data.was_one_shot <= pend_one_shot;
      out_last              <= cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = out_data;
  assign m_tlast = out_last;

endmodule

/* rtl/alarm_table_matcher.sv */
// ----------------------------------------------------------------------------
// alarm_table_matcher: alarm slot table checked against clock ticks
// Stores alarm slots and reports every slot whose time and repeat rule match
// a tick, clearing one-shot slots as they fire.
//
//   Channel  Dir  Transfer on          Content
//   s_*      in   s_tvalid & s_tready  tuser: cmd; tdata: write fields, time
//   m_*      out  m_tvalid & m_tready  tdata: fired_slot, was_one_shot; tlast
//   cfg_*    in   cfg_we               cfg_wdata: once_per_minute
//
// A write or a skipped tick is taken in the idle state alone. A scanning tick
// walks the table slots (one slot register read per cycle while not stalled)
// and then hands over the final firing in the flush state; the scan stops at
// the last slot or at the MAX_FIRINGS-th firing. The scan stalls while the
// output register stays full and another firing waits behind it.
// Reset leaves every slot invalid and no minute scanned; no clearing pass.
// ----------------------------------------------------------------------------
module alarm_table_matcher import atm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slot, entry_valid, alarm_hour, alarm_minute, repeat_weekday,
  // repeat_monthday, now_hour, now_minute, now_weekday, now_monthday, zeros
  input  logic [47:0] s_tdata,
  // cmd
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // fired_slot, was_one_shot, zeros
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  atm_cmd_t    cmd;
  atm_status_t status;

  atm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  atm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
